@@ hdl/f2dt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the float-to-decimal-text converter.
// Used by f2dt_ctrl, f2dt_datapath and float_to_decimal_text; no dependencies.
package f2dt_pkg;

    // ASCII characters of the text.
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ERROR = 8'd0;

    // Status codes of a result.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Largest integer part that converts.
    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;

    // Width of the significand with its hidden bit, and of the scaled fraction product.
    localparam int SIG_W  = 24;
    localparam int SCALE_W = 20;
    localparam int PROD_W = SIG_W + SCALE_W;

    // Decimal digits held for the integer part, and binary bits converted per value.
    localparam int INT_DIGITS_MAX = 10;
    localparam int CONV_BITS      = 32;

    // Longest text delivered for one value.
    localparam int MAX_CHARS = 16;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic conv;
        logic count;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic last;
    } stat_t;

    // Power of ten, evaluated at elaboration for the fraction scale.
    function automatic logic [SCALE_W-1:0] pow10(input int n);
        logic [SCALE_W-1:0] p;
        p = SCALE_W'(1);
        for (int i = 0; i < n; i++)
        begin
            p = SCALE_W'(p * SCALE_W'(10));
        end
        return p;
    endfunction

endpackage

@@ hdl/f2dt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the float-to-decimal-text converter: sequences decode,
// binary-to-decimal conversion and character emission. Depends on f2dt_pkg.
module f2dt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output f2dt_pkg::cmd_t  cmd,
    input  f2dt_pkg::stat_t stat
);

    f2dt_pkg::state_t state_reg;
    f2dt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= f2dt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            f2dt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = f2dt_pkg::ST_MUL;
                end
            end
            f2dt_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = f2dt_pkg::ST_SCALE;
            end
            f2dt_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = f2dt_pkg::ST_CONV;
            end
            f2dt_pkg::ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (stat.conv_done)
                begin
                    state_next = f2dt_pkg::ST_COUNT;
                end
            end
            f2dt_pkg::ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = f2dt_pkg::ST_EMIT;
            end
            f2dt_pkg::ST_EMIT:
            begin
                // A new character goes out when the output register is free or being taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last)
                    begin
                        state_next = f2dt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = f2dt_pkg::ST_IDLE;
            end
        endcase
    end

    // The output register holds a character until its transfer.
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/f2dt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the float-to-decimal-text converter: float decode, fraction
// scaling, double-dabble conversion and character selection. Depends on f2dt_pkg.
module f2dt_datapath
#(
    parameter int FRACTION_DIGITS = 4,
    parameter int INTEGER_DIGITS  = 10
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     float_bits,
    input  f2dt_pkg::cmd_t  cmd,
    output f2dt_pkg::stat_t stat,
    output logic [7:0]      text_char,
    output logic            last_char,
    output logic            status
);

    localparam int FB     = 4 * FRACTION_DIGITS;
    localparam int IB     = 4 * f2dt_pkg::INT_DIGITS_MAX;
    localparam int FIDX_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam int PW     = f2dt_pkg::PROD_W;
    localparam int SW     = f2dt_pkg::SIG_W;
    localparam logic [f2dt_pkg::SCALE_W-1:0] SCALE_C = f2dt_pkg::pow10(FRACTION_DIGITS);

    // Input and decode registers.
    logic [31:0]    bits_reg;
    logic [PW-1:0]  prod_reg;
    logic [31:0]    ipart_reg;
    logic [7:0]     k_reg;
    logic           dec_err_reg;

    // Conversion registers.
    logic [31:0]    int_bin_reg;
    logic [IB-1:0]  int_bcd_reg;
    logic [31:0]    frac_bin_reg;
    logic [FB-1:0]  frac_bcd_reg;
    logic [4:0]     conv_cnt_reg;

    // Emission registers.
    logic           err_reg;
    logic           sgn_reg;
    logic [3:0]     ni_reg;
    logic [3:0]     last_idx_reg;
    logic [3:0]     idx_reg;
    logic [7:0]     text_char_reg;
    logic           last_char_reg;
    logic           status_reg;

    // Decode signals.
    logic [7:0]     expo;
    logic [SW-1:0]  sig;
    logic [7:0]     k;
    logic [2:0]     shl;
    logic [31:0]    ipart;
    logic [SW-1:0]  rem;
    logic           dec_err;
    logic [PW-1:0]  prod;

    // Conversion and count signals.
    logic [IB-1:0]  int_adj;
    logic [FB-1:0]  frac_adj;
    logic [31:0]    fdig;
    logic [3:0]     ni;
    logic [2:0]     nf;
    logic [4:0]     total;
    logic           frac_nz;
    logic           sgn;

    // Character selection signals.
    logic [4:0]     j;
    logic [3:0]     int_pos;
    logic [4:0]     frac_off;
    logic [4:0]     frac_pos;
    logic [3:0]     digit;
    logic [7:0]     char_sel;

    // Split the float into integer part and fraction remainder.
    always_comb
    begin
        expo = bits_reg[30:23];
        shl  = 3'd0;
        if (expo == 8'd0)
        begin
            sig = {1'b0, bits_reg[22:0]};
            k   = 8'd149;
        end
        else
        begin
            sig = {1'b1, bits_reg[22:0]};
            if (expo >= 8'd150)
            begin
                k   = 8'd0;
                shl = 3'(expo - 8'd150);
            end
            else
            begin
                k = 8'd150 - expo;
            end
        end
        if (k == 8'd0)
        begin
            ipart = {8'd0, sig} << shl;
            rem   = '0;
        end
        else if (k >= 8'(SW))
        begin
            ipart = '0;
            rem   = sig;
        end
        else
        begin
            ipart = {8'd0, sig} >> k[4:0];
            rem   = sig & ((SW'(1) << k[4:0]) - SW'(1));
        end
        dec_err = (expo == 8'hFF) || (expo >= 8'd158) || (ipart > f2dt_pkg::INT_LIMIT);
    end

    // Fraction scaled by the power of ten, before the shift by the exponent.
    assign prod = PW'(rem) * PW'(SCALE_C);

    // Truncated fraction digits as a binary value.
    always_comb
    begin
        if (k_reg >= 8'(PW))
        begin
            fdig = '0;
        end
        else
        begin
            fdig = 32'(prod_reg >> k_reg[5:0]);
        end
    end

    // Double-dabble correction of every decimal digit before the shift.
    always_comb
    begin
        for (int d = 0; d < f2dt_pkg::INT_DIGITS_MAX; d++)
        begin
            int_adj[4*d +: 4] = (int_bcd_reg[4*d +: 4] >= 4'd5) ?
                                int_bcd_reg[4*d +: 4] + 4'd3 : int_bcd_reg[4*d +: 4];
        end
        for (int d = 0; d < FRACTION_DIGITS; d++)
        begin
            frac_adj[4*d +: 4] = (frac_bcd_reg[4*d +: 4] >= 4'd5) ?
                                 frac_bcd_reg[4*d +: 4] + 4'd3 : frac_bcd_reg[4*d +: 4];
        end
    end

    // Count integer digits, kept fraction digits and the text length.
    always_comb
    begin
        ni = 4'd1;
        for (int d = 0; d < f2dt_pkg::INT_DIGITS_MAX; d++)
        begin
            if (int_bcd_reg[4*d +: 4] != 4'd0)
            begin
                ni = 4'(d + 1);
            end
        end
        frac_nz = (frac_bcd_reg != '0);
        nf      = 3'd0;
        for (int d = FRACTION_DIGITS - 1; d >= 0; d--)
        begin
            if (frac_bcd_reg[4*d +: 4] != 4'd0)
            begin
                nf = 3'(FRACTION_DIGITS - d);
            end
        end
        sgn   = bits_reg[31] && ((int_bcd_reg != '0) || frac_nz);
        total = 5'(sgn) + 5'(ni) + 5'd1 + 5'(nf);
    end

    // Pick the character at the current text position.
    always_comb
    begin
        j        = 5'(idx_reg) - 5'(sgn_reg);
        int_pos  = ni_reg - 4'd1 - j[3:0];
        frac_off = j - 5'(ni_reg) - 5'd1;
        frac_pos = 5'(FRACTION_DIGITS - 1) - frac_off;
        digit    = 4'd0;
        if (sgn_reg && (idx_reg == 4'd0))
        begin
            char_sel = f2dt_pkg::CHAR_MINUS;
        end
        else if (j < 5'(ni_reg))
        begin
            digit    = int_bcd_reg[{int_pos, 2'b00} +: 4];
            char_sel = f2dt_pkg::CHAR_ZERO + {4'd0, digit};
        end
        else if (j == 5'(ni_reg))
        begin
            char_sel = f2dt_pkg::CHAR_DOT;
        end
        else
        begin
            digit    = frac_bcd_reg[{frac_pos[FIDX_W-1:0], 2'b00} +: 4];
            char_sel = f2dt_pkg::CHAR_ZERO + {4'd0, digit};
        end
    end

    // Control registers of the sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_cnt_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.scale)
            begin
                conv_cnt_reg <= '0;
            end
            else if (cmd.conv)
            begin
                conv_cnt_reg <= conv_cnt_reg + 5'd1;
            end
            if (cmd.count)
            begin
                idx_reg <= '0;
            end
            else if (cmd.emit)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg <= float_bits;
        end
        if (cmd.mul)
        begin
            prod_reg    <= prod;
            ipart_reg   <= ipart;
            k_reg       <= k;
            dec_err_reg <= dec_err;
        end
        if (cmd.scale)
        begin
            int_bin_reg  <= ipart_reg;
            int_bcd_reg  <= '0;
            frac_bin_reg <= fdig;
            frac_bcd_reg <= '0;
        end
        else if (cmd.conv)
        begin
            int_bcd_reg  <= {int_adj[IB-2:0], int_bin_reg[31]};
            int_bin_reg  <= {int_bin_reg[30:0], 1'b0};
            frac_bcd_reg <= {frac_adj[FB-2:0], frac_bin_reg[31]};
            frac_bin_reg <= {frac_bin_reg[30:0], 1'b0};
        end
        if (cmd.count)
        begin
            err_reg      <= dec_err_reg || (ni > 4'(INTEGER_DIGITS));
            sgn_reg      <= sgn;
            ni_reg       <= ni;
            last_idx_reg <= (total > 5'(f2dt_pkg::MAX_CHARS)) ?
                            4'(f2dt_pkg::MAX_CHARS - 1) : 4'(total - 5'd1);
        end
        if (cmd.emit)
        begin
            if (err_reg)
            begin
                text_char_reg <= f2dt_pkg::CHAR_ERROR;
                last_char_reg <= 1'b1;
                status_reg    <= f2dt_pkg::STATUS_ERROR;
            end
            else
            begin
                text_char_reg <= char_sel;
                last_char_reg <= (idx_reg == last_idx_reg);
                status_reg    <= f2dt_pkg::STATUS_OK;
            end
        end
    end

    assign stat.conv_done = (conv_cnt_reg == 5'(f2dt_pkg::CONV_BITS - 1));
    assign stat.last      = err_reg || (idx_reg == last_idx_reg);
    assign text_char      = text_char_reg;
    assign last_char      = last_char_reg;
    assign status         = status_reg;

endmodule

@@ hdl/float_to_decimal_text.sv @@
`timescale 1ns / 1ps
// Top level of the float-to-decimal-text converter.
// Instantiates f2dt_ctrl and f2dt_datapath; depends on f2dt_pkg.
//
// Converts one IEEE single-precision value to ASCII text, one character per
// output transfer: an optional '-', the integer part truncated toward zero,
// '.', then the fraction truncated to FRACTION_DIGITS digits with trailing
// zeros dropped; last_char marks the final character. NaN, infinity and
// integer parts that do not fit give a single result with status 1 and
// character 0. Values are handled one at a time: after the input transfer
// the block performs the fraction multiply, the exponent shift, the
// double-dabble conversion (one bit per cycle) and the digit count in
// turn, then delivers one character per cycle while the output is taken.
// The next value is accepted once the final character sits in the output
// register.
module float_to_decimal_text
#(
    parameter int FRACTION_DIGITS = 4,
    parameter int INTEGER_DIGITS  = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] float_bits,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  text_char,
    output logic        last_char,
    output logic        status,
    output logic        out_valid,
    input  logic        out_ready
);

    f2dt_pkg::cmd_t  cmd;
    f2dt_pkg::stat_t stat;

    // Sequencing of one value.
    f2dt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Arithmetic and character generation.
    f2dt_datapath
    #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .INTEGER_DIGITS  (INTEGER_DIGITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .float_bits (float_bits),
        .cmd        (cmd),
        .stat       (stat),
        .text_char  (text_char),
        .last_char  (last_char),
        .status     (status)
    );

endmodule
